FILE: hdl/xsr_pkg.sv
// types, constants and beat layouts for the segmented executable repair block
// no dependencies; used by every module under hdl
package xsr_pkg;

  localparam int MAX_RESULTS = 10;
  localparam int CNT_W       = 4;
  localparam int RUN_LEN     = 6;

  localparam logic [7:0]  MARKER_BYTE = 8'hFF;
  localparam logic [15:0] NO_START    = 16'hFFFF;
  localparam logic [15:0] RUN_VEC_LO  = 16'h02E0;
  localparam logic [15:0] RUN_VEC_HI  = 16'h02E1;
  localparam logic [15:0] INIT_VEC_LO = 16'h02E2;
  localparam logic [15:0] INIT_VEC_HI = 16'h02E3;
  localparam logic [7:0]  RUN_BYTE_0  = 8'hE0;
  localparam logic [7:0]  RUN_BYTE_1  = 8'h02;
  localparam logic [7:0]  RUN_BYTE_2  = 8'hE1;
  localparam logic [7:0]  RUN_BYTE_3  = 8'h02;

  localparam logic [1:0] STATUS_REPAIRED = 2'd0;
  localparam logic [1:0] STATUS_PASS     = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_SEGMENTED = 2'd1,
    MODE_PASS      = 2'd2,
    MODE_REJECTED  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic [1:0] file_status;
    logic       was_truncated;
    logic       run_added;
  } out_beat_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            count;
    logic                        fin;
    logic                        status_only;
    logic [1:0]                  status;
    logic                        trunc;
    logic                        added;
  } burst_t;

endpackage

FILE: hdl/xsr_parser.sv
// parser state and the per-byte result list
// depends on xsr_pkg
module xsr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  xsr_pkg::in_beat_t beat,
  output xsr_pkg::burst_t   burst,
  output logic              has_results
);

  xsr_pkg::mode_t  mode, mode_next;
  logic [2:0][7:0] hdr, hdr_next;
  logic [1:0]      hdr_count, hdr_count_next;
  logic            marker_checked, marker_checked_next;
  logic [16:0]     seg_remaining, seg_remaining_next;
  logic [15:0]     first_start, first_start_next;
  logic            run_seen, run_seen_next;
  logic            init_seen, init_seen_next;
  logic            dropping, dropping_next;

  always_comb begin
    logic [7:0]         d;
    logic               fin;
    logic [3:0][7:0]    lead;
    logic [2:0]         lead_n;
    logic [1:0]         tail_n;
    logic               add;
    logic [15:0]        start_w, stop_w;
    logic [xsr_pkg::CNT_W-1:0] base, cnt, ix, rel;
    logic [7:0]         entry;

    d   = beat.data_byte;
    fin = beat.final_byte;
    mode_next           = mode;
    hdr_next            = hdr;
    hdr_count_next      = hdr_count;
    marker_checked_next = marker_checked;
    seg_remaining_next  = seg_remaining;
    first_start_next    = first_start;
    run_seen_next       = run_seen;
    init_seen_next      = init_seen;
    dropping_next       = dropping;
    lead    = '0;
    lead_n  = 3'd0;
    start_w = {hdr[1], hdr[0]};
    stop_w  = {d, hdr[2]};

    unique case (mode)
      xsr_pkg::MODE_UNDECIDED: begin
        if (hdr_count == 2'd0) begin
          if (d != xsr_pkg::MARKER_BYTE) begin
            mode_next = xsr_pkg::MODE_PASS;
            lead[0]   = d;
            lead_n    = 3'd1;
          end else if (fin) begin
            mode_next = xsr_pkg::MODE_REJECTED;
          end else begin
            hdr_count_next = 2'd1;
          end
        end else begin
          hdr_count_next = 2'd0;
          if (d == xsr_pkg::MARKER_BYTE) begin
            mode_next           = xsr_pkg::MODE_SEGMENTED;
            marker_checked_next = 1'b0;
            lead[0]             = xsr_pkg::MARKER_BYTE;
            lead[1]             = xsr_pkg::MARKER_BYTE;
            lead_n              = 3'd2;
          end else begin
            mode_next = xsr_pkg::MODE_REJECTED;
          end
        end
      end
      xsr_pkg::MODE_SEGMENTED: begin
        if (dropping) begin
          lead_n = 3'd0;
        end else if (seg_remaining != 17'd0) begin
          lead[0]            = d;
          lead_n             = 3'd1;
          seg_remaining_next = seg_remaining - 17'd1;
        end else if (hdr_count == 2'd1 && !marker_checked &&
                     hdr[0] == xsr_pkg::MARKER_BYTE && d == xsr_pkg::MARKER_BYTE) begin
          // optional marker at a segment boundary
          hdr_count_next      = 2'd0;
          marker_checked_next = 1'b1;
        end else begin
          if (hdr_count == 2'd1) marker_checked_next = 1'b1;
          if (hdr_count != 2'd3) begin
            hdr_next[hdr_count] = d;
            hdr_count_next      = hdr_count + 2'd1;
          end else begin
            hdr_count_next      = 2'd0;
            marker_checked_next = 1'b0;
            if (start_w > stop_w) begin
              dropping_next = 1'b1;
            end else begin
              lead[0] = hdr[0];
              lead[1] = hdr[1];
              lead[2] = hdr[2];
              lead[3] = d;
              lead_n  = 3'd4;
              if (first_start == xsr_pkg::NO_START) first_start_next = start_w;
              if (start_w <= xsr_pkg::RUN_VEC_LO && stop_w >= xsr_pkg::RUN_VEC_HI)
                run_seen_next = 1'b1;
              if (start_w <= xsr_pkg::INIT_VEC_LO && stop_w >= xsr_pkg::INIT_VEC_HI)
                init_seen_next = 1'b1;
              seg_remaining_next = {1'b0, stop_w} - {1'b0, start_w} + 17'd1;
            end
          end
        end
      end
      xsr_pkg::MODE_PASS: begin
        lead[0] = d;
        lead_n  = 3'd1;
      end
      default: begin
        lead_n = 3'd0;
      end
    endcase

    // short trailing header goes out as it stands
    tail_n = (fin && mode_next == xsr_pkg::MODE_SEGMENTED && !dropping_next &&
              seg_remaining_next == 17'd0) ? hdr_count_next : 2'd0;
    add    = fin && mode_next == xsr_pkg::MODE_SEGMENTED && !run_seen_next &&
             !init_seen_next;
    base   = {1'b0, lead_n} + {2'b00, tail_n};
    cnt    = base + (add ? xsr_pkg::CNT_W'(xsr_pkg::RUN_LEN) : '0);

    burst.status_only = fin && cnt == '0;
    burst.count       = burst.status_only ? xsr_pkg::CNT_W'(1) : cnt;
    burst.fin         = fin;
    burst.trunc       = dropping_next;
    burst.added       = add;
    unique case (mode_next)
      xsr_pkg::MODE_SEGMENTED: burst.status = xsr_pkg::STATUS_REPAIRED;
      xsr_pkg::MODE_REJECTED:  burst.status = xsr_pkg::STATUS_REJECTED;
      default:                 burst.status = xsr_pkg::STATUS_PASS;
    endcase

    for (int i = 0; i < xsr_pkg::MAX_RESULTS; i++) begin
      ix    = xsr_pkg::CNT_W'(i);
      entry = 8'h00;
      if (ix < {1'b0, lead_n}) begin
        entry = lead[ix[1:0]];
      end else if (ix < base) begin
        rel   = ix - {1'b0, lead_n};
        entry = hdr_next[rel[1:0]];
      end else if (add && ix < cnt) begin
        rel = ix - base;
        unique case (rel[2:0])
          3'd0:    entry = xsr_pkg::RUN_BYTE_0;
          3'd1:    entry = xsr_pkg::RUN_BYTE_1;
          3'd2:    entry = xsr_pkg::RUN_BYTE_2;
          3'd3:    entry = xsr_pkg::RUN_BYTE_3;
          3'd4:    entry = first_start_next[7:0];
          default: entry = first_start_next[15:8];
        endcase
      end
      burst.bytes[i] = entry;
    end
    has_results = burst.count != '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && beat.final_byte)) begin
      mode           <= xsr_pkg::MODE_UNDECIDED;
      hdr_count      <= 2'd0;
      marker_checked <= 1'b0;
      seg_remaining  <= 17'd0;
      first_start    <= xsr_pkg::NO_START;
      run_seen       <= 1'b0;
      init_seen      <= 1'b0;
      dropping       <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      hdr_count      <= hdr_count_next;
      marker_checked <= marker_checked_next;
      seg_remaining  <= seg_remaining_next;
      first_start    <= first_start_next;
      run_seen       <= run_seen_next;
      init_seen      <= init_seen_next;
      dropping       <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hdr <= hdr_next;
  end

endmodule

FILE: hdl/xsr_emit.sv
// result buffer for one byte's burst and the output register
// depends on xsr_pkg
module xsr_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  xsr_pkg::burst_t    load_burst,
  output logic               can_load,
  output logic               valid,
  input  logic               stall,
  output xsr_pkg::out_beat_t beat
);

  xsr_pkg::burst_t           pend;
  logic [xsr_pkg::CNT_W-1:0] idx;
  logic                      busy;
  logic                      pop;
  logic                      last_entry;

  assign last_entry = idx == pend.count - xsr_pkg::CNT_W'(1);
  assign pop        = busy && (!valid || !stall);
  assign can_load   = !busy || (pop && last_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (pop && last_entry) begin
        busy <= 1'b0;
      end
      if (load) begin
        idx <= '0;
      end else if (pop) begin
        idx <= idx + xsr_pkg::CNT_W'(1);
      end
      if (pop) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) pend <= load_burst;
    if (pop) begin
      beat.out_byte      <= pend.status_only ? 8'h00 : pend.bytes[idx];
      beat.byte_valid    <= !pend.status_only;
      beat.out_last      <= pend.fin && last_entry;
      beat.file_status   <= pend.status;
      beat.was_truncated <= pend.trunc;
      beat.run_added     <= pend.added;
    end
  end

endmodule

FILE: hdl/xex_segment_repair.sv
// path: a byte's results pass the burst buffer, then the output register
// throughput: one input byte per cycle while the output is not stalled and each byte
//   gives at most one result; a byte giving more (up to ten) holds the output port
// reset: synchronous, active high; parser returns to undecided, buffers empty
// depends on xsr_pkg, xsr_parser, xsr_emit
module xex_segment_repair (
  input  logic               clk,
  input  logic               rst,
  input  logic               raw_valid,
  output logic               raw_stall,
  input  xsr_pkg::in_beat_t  raw,
  output logic               fixed_valid,
  input  logic               fixed_stall,
  output xsr_pkg::out_beat_t fixed
);

  // a byte is taken whenever the burst buffer is free or drains its last entry
  logic            accept;
  logic            can_load;
  logic            has_results;
  xsr_pkg::burst_t burst;

  assign raw_stall = !can_load;
  assign accept    = raw_valid && !raw_stall;

  // parser: format decision, header collection, segment counting, vector checks
  xsr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .beat        (raw),
    .burst       (burst),
    .has_results (has_results)
  );

  // bytes that only feed the parser (held headers, markers, dropped tail)
  // never occupy the burst buffer
  xsr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && has_results),
    .load_burst (burst),
    .can_load   (can_load),
    .valid      (fixed_valid),
    .stall      (fixed_stall),
    .beat       (fixed)
  );

`ifndef SYNTHESIS
  // a status-only beat only ever closes a file
  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    fixed_valid && !fixed.byte_valid |-> fixed.out_last)
    else $error("status-only beat without last");

  // appended run segment only for a segmented file
  a_run_needs_segments: assert property (@(posedge clk) disable iff (rst)
    fixed_valid && fixed.run_added |-> fixed.file_status == xsr_pkg::STATUS_REPAIRED)
    else $error("run segment on a non-segmented file");

  // a rejected file yields no data bytes
  a_reject_no_bytes: assert property (@(posedge clk) disable iff (rst)
    fixed_valid && fixed.file_status == xsr_pkg::STATUS_REJECTED |-> !fixed.byte_valid)
    else $error("data byte on a rejected file");

  // a byte with results is never taken while an earlier burst still has entries
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && has_results |-> can_load)
    else $error("burst buffer overrun");
`endif

endmodule
